@@ hw/rtl/sidiv_pkg.sv @@
// shared width, status codes and request/response/pipeline types for the signed divider
package sidiv_pkg;

    localparam int DATA_WIDTH = 32;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] dividend;
        logic signed [DATA_WIDTH-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quotient;
        logic signed [DATA_WIDTH-1:0] remainder;
        logic [1:0]                   status;
    } rsp_t;

    typedef struct packed {
        logic       dd_neg;
        logic       q_neg;
        logic [1:0] status;
    } ctl_t;

    // one pipeline slot: quo starts as the dividend magnitude and fills with quotient bits
    typedef struct packed {
        logic                  valid;
        ctl_t                  ctl;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] dsr;
    } work_t;

endpackage

@@ hw/rtl/sidiv_prep.sv @@
// input stage: operand magnitudes, result signs and status
module sidiv_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              valid,
    input  sidiv_pkg::req_t   data,
    output sidiv_pkg::work_t  work
);

    logic [sidiv_pkg::DATA_WIDTH-1:0] dd;
    logic [sidiv_pkg::DATA_WIDTH-1:0] dv;
    logic                             dd_neg;
    logic                             dv_neg;
    logic                             valid_reg;
    logic                             valid_next;
    sidiv_pkg::work_t                 slot_reg;
    sidiv_pkg::work_t                 slot_next;

    assign dd     = data.dividend;
    assign dv     = data.divisor;
    assign dd_neg = dd[sidiv_pkg::DATA_WIDTH-1];
    assign dv_neg = dv[sidiv_pkg::DATA_WIDTH-1];

    always_comb
    begin
        slot_next            = '0;
        slot_next.ctl.dd_neg = dd_neg;
        slot_next.ctl.q_neg  = dd_neg ^ dv_neg;
        slot_next.quo        = dd_neg ? ('0 - dd) : dd;
        slot_next.dsr        = dv_neg ? ('0 - dv) : dv;
        slot_next.rem        = '0;
        priority if (dv == '0)
        begin
            slot_next.ctl.status = sidiv_pkg::ST_DIV_ZERO;
        end
        else if (dd == {1'b1, {(sidiv_pkg::DATA_WIDTH-1){1'b0}}} && dv == '1)
        begin
            slot_next.ctl.status = sidiv_pkg::ST_OVERFLOW;
        end
        else
        begin
            slot_next.ctl.status = sidiv_pkg::ST_OK;
        end
        valid_next = valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_reg <= slot_next;
        end
    end

    always_comb
    begin
        work       = slot_reg;
        work.valid = valid_reg;
    end

endmodule

@@ hw/rtl/sidiv_step.sv @@
// one restoring division step: retires one quotient bit per stage
module sidiv_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sidiv_pkg::work_t  work_in,
    output sidiv_pkg::work_t  work_out
);

    logic [sidiv_pkg::DATA_WIDTH-1:0] rem_sh;
    logic [sidiv_pkg::DATA_WIDTH:0]   diff;
    logic                             valid_reg;
    sidiv_pkg::work_t                 slot_reg;
    sidiv_pkg::work_t                 slot_next;

    // partial remainder stays below the divisor, so the shift never loses a bit
    assign rem_sh = {work_in.rem[sidiv_pkg::DATA_WIDTH-2:0],
                     work_in.quo[sidiv_pkg::DATA_WIDTH-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, work_in.dsr};

    always_comb
    begin
        slot_next = work_in;
        if (!diff[sidiv_pkg::DATA_WIDTH])
        begin
            slot_next.rem = diff[sidiv_pkg::DATA_WIDTH-1:0];
            slot_next.quo = {work_in.quo[sidiv_pkg::DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            slot_next.rem = rem_sh;
            slot_next.quo = {work_in.quo[sidiv_pkg::DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= work_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_reg <= slot_next;
        end
    end

    always_comb
    begin
        work_out       = slot_reg;
        work_out.valid = valid_reg;
    end

endmodule

@@ hw/rtl/sidiv_fix.sv @@
// output stage: sign correction, zero-divisor override and response register
module sidiv_fix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sidiv_pkg::work_t  work,
    output logic              valid,
    output sidiv_pkg::rsp_t   data
);

    logic            valid_reg;
    sidiv_pkg::rsp_t rsp_reg;
    sidiv_pkg::rsp_t rsp_next;

    always_comb
    begin
        rsp_next.status = work.ctl.status;
        if (work.ctl.status == sidiv_pkg::ST_DIV_ZERO)
        begin
            rsp_next.quotient  = '0;
            rsp_next.remainder = '0;
        end
        else
        begin
            // most negative over minus one wraps back to itself here
            rsp_next.quotient  = work.ctl.q_neg  ? ('0 - work.quo) : work.quo;
            rsp_next.remainder = work.ctl.dd_neg ? ('0 - work.rem) : work.rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= work.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign valid = valid_reg;
    assign data  = rsp_reg;

endmodule

@@ hw/rtl/signed_integer_divider_core.sv @@
// top level of the pipelined signed divider
// Signed divider with C semantics: quotient truncated toward zero, remainder
// taking the dividend's sign. A zero divisor returns status divide-by-zero
// with zero quotient and remainder; the most negative value divided by minus
// one returns status overflow, the wrapped quotient and remainder zero. The
// pipeline takes a new request every clock unless it is held, and each
// result passes through one operand stage, one subtract stage per quotient
// bit and one sign-correction and output stage.
// The whole pipeline holds while a response is waiting and rsp_stall is high.
module signed_integer_divider_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  sidiv_pkg::req_t  req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output sidiv_pkg::rsp_t  rsp_data
);

    sidiv_pkg::work_t                 work [sidiv_pkg::DATA_WIDTH+1];
    logic [sidiv_pkg::DATA_WIDTH:0]   stage_valid;
    logic                             advance;

    // the output register can take a new value when empty or being drained
    assign advance   = !rsp_valid || !rsp_stall;
    assign req_stall = !advance;

    sidiv_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .valid   (req_valid),
        .data    (req_data),
        .work    (work[0])
    );

    for (genvar k = 0; k < sidiv_pkg::DATA_WIDTH; k++)
    begin : g_step
        sidiv_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .work_in  (work[k]),
            .work_out (work[k+1])
        );
    end

    for (genvar k = 0; k <= sidiv_pkg::DATA_WIDTH; k++)
    begin : g_valid
        assign stage_valid[k] = work[k].valid;
    end

    sidiv_fix u_fix (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .work    (work[sidiv_pkg::DATA_WIDTH]),
        .valid   (rsp_valid),
        .data    (rsp_data)
    );

    a_zero_div_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == sidiv_pkg::ST_DIV_ZERO
            |-> rsp_data.quotient == '0 && rsp_data.remainder == '0)
        else $error("divide by zero response carries nonzero data");

    a_overflow_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == sidiv_pkg::ST_OVERFLOW
            |-> rsp_data.quotient == {1'b1, {(sidiv_pkg::DATA_WIDTH-1){1'b0}}}
                && rsp_data.remainder == '0)
        else $error("overflow response is not the wrapped quotient");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(stage_valid))
        else $error("pipeline moved while the response was stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status == sidiv_pkg::ST_OK
            || rsp_data.status == sidiv_pkg::ST_DIV_ZERO
            || rsp_data.status == sidiv_pkg::ST_OVERFLOW)
        else $error("undefined status code on response");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the pipelined signed divider: c-style truncating division with status
module testbench;

    localparam logic signed [sidiv_pkg::DATA_WIDTH-1:0] MOST_NEG =
        {1'b1, {(sidiv_pkg::DATA_WIDTH-1){1'b0}}};
    localparam logic signed [sidiv_pkg::DATA_WIDTH-1:0] MOST_POS = ~MOST_NEG;
    localparam logic signed [sidiv_pkg::DATA_WIDTH-1:0] MINUS_ONE = '1;
    localparam int RANDOM_REQUESTS = 1900;
    localparam int IDLE_PERCENT = 38;
    localparam int HOLD_AT_RESULT = 500;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    sidiv_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    sidiv_pkg::rsp_t rsp_data;

    sidiv_pkg::req_t operand_queue[$];
    sidiv_pkg::rsp_t divisions_due[$];
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    bit hold_done = 1'b0;
    int unsigned error_count = 0;

    signed_integer_divider_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // truncating signed division, remainder follows the dividend
    function automatic sidiv_pkg::rsp_t divide_trunc(sidiv_pkg::req_t op);
        logic [sidiv_pkg::DATA_WIDTH-1:0] num;
        logic [sidiv_pkg::DATA_WIDTH-1:0] den;
        logic [sidiv_pkg::DATA_WIDTH-1:0] mag_num;
        logic [sidiv_pkg::DATA_WIDTH-1:0] mag_den;
        logic [sidiv_pkg::DATA_WIDTH-1:0] quo;
        logic [sidiv_pkg::DATA_WIDTH-1:0] rem;
        logic                             num_neg;
        logic                             den_neg;
        sidiv_pkg::rsp_t                  res;
        num = op.dividend;
        den = op.divisor;
        if (den == '0)
        begin
            res.quotient  = '0;
            res.remainder = '0;
            res.status    = sidiv_pkg::ST_DIV_ZERO;
            return res;
        end
        num_neg = num[sidiv_pkg::DATA_WIDTH-1];
        den_neg = den[sidiv_pkg::DATA_WIDTH-1];
        mag_num = num_neg ? -num : num;
        mag_den = den_neg ? -den : den;
        quo = mag_num / mag_den;
        rem = mag_num % mag_den;
        if (num_neg != den_neg)
            quo = -quo;
        if (num_neg)
            rem = -rem;
        res.quotient  = quo;
        res.remainder = rem;
        res.status    = (num == MOST_NEG && den == MINUS_ONE) ? sidiv_pkg::ST_OVERFLOW
                                                              : sidiv_pkg::ST_OK;
        return res;
    endfunction

    // a window in the middle of the random part runs with no idling on either side
    function automatic bit take_break();
        int unsigned left;
        left = operand_queue.size();
        if (left >= 700 && left < 1000)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_op(logic signed [sidiv_pkg::DATA_WIDTH-1:0] num,
                            logic signed [sidiv_pkg::DATA_WIDTH-1:0] den);
        sidiv_pkg::req_t op;
        op.dividend = num;
        op.divisor  = den;
        operand_queue.push_back(op);
    endtask

    function automatic logic signed [sidiv_pkg::DATA_WIDTH-1:0] small_value();
        return int'($urandom_range(0, 40)) - 20;
    endfunction

    function automatic logic signed [sidiv_pkg::DATA_WIDTH-1:0] mid_value();
        logic signed [sidiv_pkg::DATA_WIDTH-1:0] v;
        v = $urandom >> $urandom_range(0, sidiv_pkg::DATA_WIDTH - 1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic signed [sidiv_pkg::DATA_WIDTH-1:0] edge_value();
        case ($urandom_range(0, 5))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return MINUS_ONE;
            3: return 1;
            4: return MOST_NEG + 1;
            default: return 0;
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                divisions_due.push_back(divide_trunc(req_data));
            if (!req_valid || !req_stall)
            begin
                if (operand_queue.size() != 0 && !take_break())
                begin
                    req_valid <= 1'b1;
                    req_data  <= operand_queue.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the pipeline fills and pushes back on requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen == HOLD_AT_RESULT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        sidiv_pkg::rsp_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_seen <= results_seen + 1;
                if (divisions_due.size() == 0)
                    report_mismatch("result with no request pending");
                else
                begin
                    want = divisions_due.pop_front();
                    if (rsp_data.quotient !== want.quotient)
                        report_mismatch($sformatf("quotient %h, expected %h",
                                                  rsp_data.quotient, want.quotient));
                    if (rsp_data.remainder !== want.remainder)
                        report_mismatch($sformatf("remainder %h, expected %h",
                                                  rsp_data.remainder, want.remainder));
                    if (rsp_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_data.status, want.status));
                end
            end
            rsp_stall <= (hold_left != 0) || take_break();
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        sidiv_pkg::req_t op;
        // directed corners: zeros, extremes, overflow, sign combinations
        queue_op(0, 1);
        queue_op(0, MINUS_ONE);
        queue_op(MOST_POS, 1);
        queue_op(MOST_POS, MINUS_ONE);
        queue_op(MOST_NEG, 1);
        queue_op(MOST_NEG, MINUS_ONE);
        queue_op(MOST_NEG, MOST_NEG);
        queue_op(MOST_POS, MOST_POS);
        queue_op(MOST_NEG, MOST_POS);
        queue_op(MOST_POS, MOST_NEG);
        queue_op(0, 0);
        queue_op(MOST_NEG, 0);
        queue_op(MOST_POS, 0);
        queue_op(MINUS_ONE, 0);
        queue_op(-7, 2);
        queue_op(7, -2);
        queue_op(-7, -2);
        queue_op(7, 2);
        queue_op(1, MOST_POS);
        queue_op(MINUS_ONE, MOST_NEG);
        queue_op(MOST_NEG, 2);
        queue_op(5, 5);
        queue_op(-5, 5);
        queue_op(3, 7);
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    op.dividend = $urandom;
                    op.divisor  = $urandom;
                end
                3:
                begin
                    op.dividend = small_value();
                    op.divisor  = small_value();
                end
                4:
                begin
                    op.dividend = $urandom;
                    op.divisor  = small_value();
                end
                5:
                begin
                    op.dividend = edge_value();
                    op.divisor  = $urandom_range(0, 1) ? edge_value() : mid_value();
                end
                6:
                begin
                    op.dividend = $urandom_range(0, 1) ? $urandom : mid_value();
                    op.divisor  = 0;
                end
                7:
                begin
                    op.dividend = $urandom;
                    op.divisor  = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
                end
                8:
                begin
                    op.dividend = mid_value();
                    op.divisor  = mid_value();
                end
                default:
                begin
                    // exact multiples and near misses
                    op.divisor  = mid_value() >>> $urandom_range(0, 8);
                    op.dividend = op.divisor * int'($urandom_range(0, 7))
                                  + int'($urandom_range(0, 2)) - 1;
                    if ($urandom_range(0, 1))
                        op.dividend = -op.dividend;
                end
            endcase
            operand_queue.push_back(op);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (operand_queue.size() != 0 || req_valid)
            @(posedge clk);
        while (divisions_due.size() != 0)
            @(posedge clk);
        repeat (2 * sidiv_pkg::DATA_WIDTH + 8) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ signed_integer_divider_core.f @@
hw/rtl/sidiv_pkg.sv
hw/rtl/sidiv_prep.sv
hw/rtl/sidiv_step.sv
hw/rtl/sidiv_fix.sv
hw/rtl/signed_integer_divider_core.sv
tb/testbench.sv
